FILE: rtl/core/wts_pkg.sv
// Shared constants, register codes and stage payload types for the weight path.
package wts_pkg;

   localparam int RAW_W      = 24;
   localparam int SCALE_W    = 32;
   localparam int BAND_W     = 16;
   localparam int COUNT_W    = 8;
   localparam int WEIGHT_W   = 32;
   localparam int PROD_W     = RAW_W + SCALE_W;
   // Q8.24 coefficient times raw count, kept in 1/16 units: drop 24 - 4 bits
   localparam int FRAC_SHIFT = 20;

   // Averaging window; a power of two so the mean is a plain shift
   localparam int WINDOW     = 8;
   localparam int WIN_LOG2   = $clog2(WINDOW);
   localparam int POS_W      = WIN_LOG2;
   localparam int SUM_W      = WEIGHT_W + WIN_LOG2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARE_OFFSET  = 2'd0,
      CSR_SCALE_FACTOR = 2'd1,
      CSR_STABLE_BAND  = 2'd2,
      CSR_STABLE_COUNT = 2'd3
   } csr_index_type;

   localparam logic [RAW_W-1:0]   TARE_RESET  = 24'd21686;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd38476;
   localparam logic [BAND_W-1:0]  BAND_RESET  = 16'd32;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd10;

   typedef struct packed {
      logic [RAW_W-1:0]   tare_offset;
      logic [SCALE_W-1:0] scale_factor;
      logic [BAND_W-1:0]  stable_band;
      logic [COUNT_W-1:0] stable_count;
   } cfg_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] sample_weight;
      logic [SUM_W-1:0]    window_sum;
   } win_type;

endpackage

FILE: rtl/core/wts_req_if.sv
// Raw sample channel: valid/ready handshake carrying one converter reading.
interface wts_req_if import wts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

FILE: rtl/core/wts_rsp_if.sv
// Result channel: valid/ready handshake carrying sample weight, mean and stable flag.
interface wts_rsp_if import wts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] sample_weight;
   logic [WEIGHT_W-1:0] avg_weight;
   logic                is_stable;

   modport source (output valid, output sample_weight, output avg_weight,
                   output is_stable, input ready);
   modport sink   (input valid, input sample_weight, input avg_weight,
                   input is_stable, output ready);
endinterface

FILE: rtl/core/wts_front.sv
// Tare subtract stage followed by the scaling multiply stage.
module wts_front import wts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [RAW_W-1:0]    raw_sample,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [PROD_W-1:0]   product
);

   logic              diff_vld_ff;
   logic [RAW_W-1:0]  diff_ff;
   logic [RAW_W-1:0]  diff_in;
   logic              prod_vld_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic              diff_en;
   logic              prod_en;

   assign prod_en  = !prod_vld_ff || out_ready;
   assign diff_en  = !diff_vld_ff || prod_en;
   assign in_ready = diff_en;

   // Zero weight when the sample is not above the tare
   assign diff_in = (raw_sample > cfg.tare_offset) ? (raw_sample - cfg.tare_offset)
                                                   : '0;
   assign prod_in = PROD_W'(diff_ff) * PROD_W'(cfg.scale_factor);

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         if (diff_en) begin
            diff_vld_ff <= in_valid;
         end
         if (prod_en) begin
            prod_vld_ff <= diff_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (diff_en && in_valid) begin
         diff_ff <= diff_in;
      end
      if (prod_en && diff_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = prod_vld_ff;
   assign product   = prod_ff;

endmodule

FILE: rtl/core/wts_window.sv
// Saturation to 1/16 units and the running window sum over the newest samples.
module wts_window import wts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [PROD_W-1:0] product,
   output logic              out_valid,
   input  logic              out_ready,
   output win_type           win
);

   logic [WEIGHT_W-1:0] store_ff [WINDOW];
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [WEIGHT_W-1:0] weight_in;
   logic                vld_ff;
   logic                en;
   logic                take;

   assign en       = !vld_ff || out_ready;
   assign in_ready = en;
   assign take     = in_valid && en;

   // Anything above the 32-bit weight range saturates to all ones
   assign weight_in = (|product[PROD_W-1:FRAC_SHIFT+WEIGHT_W]) ? '1
                                                               : product[FRAC_SHIFT +: WEIGHT_W];
   assign sum_in    = sum_ff - SUM_W'(store_ff[pos_ff]) + SUM_W'(weight_in);
   assign pos_in    = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         pos_ff <= '0;
         sum_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (en) begin
            vld_ff <= in_valid;
         end
         if (take) begin
            store_ff[pos_ff] <= weight_in;
            pos_ff           <= pos_in;
            sum_ff           <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         weight_ff <= weight_in;
      end
   end

   assign out_valid         = vld_ff;
   assign win.sample_weight = weight_ff;
   assign win.window_sum    = sum_ff;

endmodule

FILE: rtl/core/wts_stable.sv
// Mean of the window, stability tracking and the result register.
module wts_stable import wts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  win_type             win,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [WEIGHT_W-1:0] sample_weight,
   output logic [WEIGHT_W-1:0] avg_weight,
   output logic                is_stable
);

   logic                vld_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [WEIGHT_W-1:0] prev_avg_ff;
   logic [COUNT_W-1:0]  steady_cnt_ff;
   logic [COUNT_W-1:0]  steady_cnt_in;
   logic                stable_flag_ff;
   logic                stable_flag_in;
   logic [WEIGHT_W-1:0] avg_in;
   logic [WEIGHT_W-1:0] delta;
   logic                steady;
   logic                en;
   logic                take;

   assign en       = !vld_ff || out_ready;
   assign in_ready = en;
   assign take     = in_valid && en;

   assign avg_in = win.window_sum[SUM_W-1:WIN_LOG2];
   assign delta  = (avg_in >= prev_avg_ff) ? (avg_in - prev_avg_ff) : (prev_avg_ff - avg_in);
   assign steady = delta < WEIGHT_W'(cfg.stable_band);

   always_comb begin
      steady_cnt_in  = steady_cnt_ff;
      stable_flag_in = stable_flag_ff;
      if (steady) begin
         if (steady_cnt_ff >= cfg.stable_count) begin
            stable_flag_in = 1'b1;
         end else begin
            steady_cnt_in = steady_cnt_ff + 1'b1;
         end
      end else begin
         steady_cnt_in  = '0;
         stable_flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff         <= 1'b0;
         prev_avg_ff    <= '0;
         steady_cnt_ff  <= '0;
         stable_flag_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= in_valid;
         end
         if (take) begin
            prev_avg_ff    <= avg_in;
            steady_cnt_ff  <= steady_cnt_in;
            stable_flag_ff <= stable_flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         weight_ff <= win.sample_weight;
      end
   end

   // The stored previous mean and flag are exactly this item's results
   assign out_valid     = vld_ff;
   assign sample_weight = weight_ff;
   assign avg_weight    = prev_avg_ff;
   assign is_stable     = stable_flag_ff;

endmodule

FILE: rtl/core/weight_tare_scale_average.sv
// Load-cell weight path top level: tare, scale, moving average and stable flag.
// A req transfer loads the tare-subtract register; the multiply, window sum and result registers then
//   follow in order, and the result register drives rsp.
// Throughput: one sample per cycle; each stage advances while its successor has room.
// Reset (synchronous): config registers return to defaults, window entries, running sum,
//   previous mean, steady counter and flag clear; pipeline empties.
module weight_tare_scale_average import wts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wts_req_if.sink               req_chan,
   wts_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers; the user must write them only while the pipe is empty (not enforced here)
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tare_offset  <= TARE_RESET;
         cfg_ff.scale_factor <= SCALE_RESET;
         cfg_ff.stable_band  <= BAND_RESET;
         cfg_ff.stable_count <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TARE_OFFSET: begin
               cfg_ff.tare_offset <= csr_wdata[RAW_W-1:0];
            end
            CSR_SCALE_FACTOR: begin
               cfg_ff.scale_factor <= csr_wdata[SCALE_W-1:0];
            end
            CSR_STABLE_BAND: begin
               cfg_ff.stable_band <= csr_wdata[BAND_W-1:0];
            end
            CSR_STABLE_COUNT: begin
               cfg_ff.stable_count <= csr_wdata[COUNT_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Stage interconnect
   logic              prod_valid;
   logic              prod_ready;
   logic [PROD_W-1:0] product;
   logic              win_valid;
   logic              win_ready;
   win_type           win;

   // Tare subtract, then Q8.24 multiply
   wts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .raw_sample (req_chan.raw_sample),
      .out_valid  (prod_valid),
      .out_ready  (prod_ready),
      .product    (product)
   );

   // Saturate to 1/16 units; replace the oldest window entry in the running sum
   wts_window u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .product   (product),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .win       (win)
   );

   // Mean, steadiness against previous mean, result register
   wts_stable u_stable (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (win_valid),
      .in_ready      (win_ready),
      .win           (win),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .sample_weight (rsp_chan.sample_weight),
      .avg_weight    (rsp_chan.avg_weight),
      .is_stable     (rsp_chan.is_stable)
   );

endmodule

FILE: tb/tb_weight_tare_scale_average.sv
// Self-checking testbench for the load-cell tare/scale/moving-average/stable-flag path.
`timescale 1ns / 100ps

module tb_weight_tare_scale_average;
   import wts_pkg::*;

   // Watchdog: cycles without any transfer before the run is declared hung.
   // The longest legal quiet stretch is the receiver's long hold-off.
   localparam int unsigned HANG_LIMIT = 2000;
   // Quiet cycles after the last expected result, to catch stray results.
   localparam int unsigned TAIL_CYCLES = 16;

   typedef struct packed {
      logic [WEIGHT_W-1:0] sample_weight;
      logic [WEIGHT_W-1:0] avg_weight;
      logic                is_stable;
   } weight_result_type;

   // Predictor of the weight path plus the queue of readings still owed.
   class weight_scoreboard;
      logic [RAW_W-1:0]    tare_offset;
      logic [SCALE_W-1:0]  scale_factor;
      logic [BAND_W-1:0]   stable_band;
      logic [COUNT_W-1:0]  stable_count;

      logic [WEIGHT_W-1:0] window_store[WINDOW];
      logic [SUM_W-1:0]    window_sum;
      int unsigned         wr_pos;
      logic [WEIGHT_W-1:0] prev_avg;
      logic [COUNT_W-1:0]  steady_run;
      logic                stable;

      weight_result_type   expected_q[$];
      int unsigned         errors;
      int unsigned         checked;
      int unsigned         stable_hits;
      int unsigned         saturated;

      function new();
         tare_offset  = TARE_RESET;
         scale_factor = SCALE_RESET;
         stable_band  = BAND_RESET;
         stable_count = COUNT_RESET;
         foreach (window_store[k]) window_store[k] = '0;
         window_sum  = '0;
         wr_pos      = 0;
         prev_avg    = '0;
         steady_run  = '0;
         stable      = 1'b0;
         errors      = 0;
         checked     = 0;
         stable_hits = 0;
         saturated   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TARE_OFFSET:  tare_offset  = data[RAW_W-1:0];
            CSR_SCALE_FACTOR: scale_factor = data[SCALE_W-1:0];
            CSR_STABLE_BAND:  stable_band  = data[BAND_W-1:0];
            CSR_STABLE_COUNT: stable_count = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Accepted raw sample: advance the predicted state, queue the reading.
      function void note_sample(logic [RAW_W-1:0] raw);
         logic [PROD_W-1:0]   diff;
         logic [PROD_W-1:0]   product;
         logic [WEIGHT_W-1:0] weight;
         logic [WEIGHT_W-1:0] avg;
         logic [WEIGHT_W-1:0] delta;
         weight_result_type   want;
         diff    = (raw > tare_offset) ? PROD_W'(raw - tare_offset) : '0;
         product = diff * scale_factor;
         if (|product[PROD_W-1:FRAC_SHIFT+WEIGHT_W]) begin
            weight = '1;
            saturated++;
         end else begin
            weight = product[FRAC_SHIFT +: WEIGHT_W];
         end
         window_sum           = window_sum - window_store[wr_pos] + weight;
         window_store[wr_pos] = weight;
         wr_pos               = (wr_pos + 1) % WINDOW;
         avg                  = WEIGHT_W'(window_sum / WINDOW);
         delta = (avg >= prev_avg) ? avg - prev_avg : prev_avg - avg;
         if (delta < stable_band) begin
            if (steady_run >= stable_count) stable = 1'b1;
            else steady_run = steady_run + 1'b1;
         end else begin
            steady_run = '0;
            stable     = 1'b0;
         end
         prev_avg           = avg;
         want.sample_weight = weight;
         want.avg_weight    = avg;
         want.is_stable     = stable;
         expected_q.push_back(want);
      endfunction

      function void check_result(logic [WEIGHT_W-1:0] weight, logic [WEIGHT_W-1:0] avg,
                                 logic flag);
         weight_result_type want;
         checked++;
         if (expected_q.size() == 0) begin
            $error("unexpected reading: sample_weight %0h avg_weight %0h is_stable %0b",
                   weight, avg, flag);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (want.is_stable) stable_hits++;
         if (weight !== want.sample_weight) begin
            $error("sample_weight expected %0h actual %0h", want.sample_weight, weight);
            errors++;
         end
         if (avg !== want.avg_weight) begin
            $error("avg_weight expected %0h actual %0h", want.avg_weight, avg);
            errors++;
         end
         if (flag !== want.is_stable) begin
            $error("is_stable expected %0b actual %0b", want.is_stable, flag);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wts_req_if req_if ();
   wts_rsp_if rsp_if ();

   weight_tare_scale_average u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   weight_scoreboard sb = new();

   bit          burst_mode;      // no random gaps on either side while set; a requested hold-off still applies
   bit          hold_request;    // asks the receiver for one long hold-off
   int unsigned samples_sent;
   int unsigned settings_count;
   int unsigned quiet_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Driver tasks
   // ---------------------------------------------------------------------

   // One register write; the register takes the value at the next edge.
   // csr_we is left high so back-to-back writes never drop it mid-step.
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Full register set; only called with the pipeline empty.
   task automatic apply_config(logic [RAW_W-1:0] tare, logic [SCALE_W-1:0] scale,
                               logic [BAND_W-1:0] band, logic [COUNT_W-1:0] count);
      write_csr(CSR_TARE_OFFSET,  CSR_DATA_W'(tare));
      write_csr(CSR_SCALE_FACTOR, CSR_DATA_W'(scale));
      write_csr(CSR_STABLE_BAND,  CSR_DATA_W'(band));
      write_csr(CSR_STABLE_COUNT, CSR_DATA_W'(count));
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // Offer one sample after a random gap (none in burst mode), return at the edge of its transfer.
   // valid stays high on exit so a zero gap gives back-to-back transfers.
   task automatic send_sample(logic [RAW_W-1:0] raw);
      int unsigned gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.raw_sample <= raw;
      do @(posedge clock); while (!req_if.ready);
      sb.note_sample(raw);
      samples_sent++;
   endtask

   // Drop valid and wait for every owed reading. Each sample yields exactly
   // one reading, so an empty queue means the pipeline is empty too.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Mostly steady runs (a level at or above tare plus a little noise) so
   // the mean settles and the stable counter gets exercised; the rest is
   // samples at or below tare and raw noise over the full 24 bits.
   task automatic run_mixed(int unsigned n_items, bit do_hold);
      int unsigned    first;
      int unsigned    kind;
      int unsigned    run_len;
      int unsigned    span;
      int unsigned    noise_w;
      logic [RAW_W:0] level;
      logic [RAW_W:0] pick;
      first = samples_sent;
      while (samples_sent - first < n_items) begin
         if (do_hold && (samples_sent - first >= n_items / 2)) begin
            hold_request = 1'b1;
            do_hold      = 1'b0;
         end
         kind    = $urandom_range(0, 9);
         run_len = $urandom_range(1, 10);
         if (kind <= 6) begin
            span    = $urandom_range(0, RAW_W - 1);
            noise_w = $urandom_range(0, 6);
            run_len = $urandom_range(8, 40);
            level   = (RAW_W+1)'(sb.tare_offset) + (RAW_W+1)'($urandom & ((1 << span) - 1));
            repeat (run_len) begin
               pick = level + (RAW_W+1)'($urandom & ((1 << noise_w) - 1));
               send_sample(pick[RAW_W] ? {RAW_W{1'b1}} : pick[RAW_W-1:0]);
            end
         end else if (kind == 7) begin
            repeat (run_len) send_sample(RAW_W'($urandom_range(0, sb.tare_offset)));
         end else begin
            repeat (run_len) send_sample(RAW_W'($urandom));
         end
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Result side: random ready gaps per reading, plus one long hold-off on
   // request, counted here so the sender keeps pushing into a full pipe.
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int unsigned wait_left;
      int unsigned hold_left;
      wait_left = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else begin
            if (rsp_if.valid && rsp_if.ready) begin
               sb.check_result(rsp_if.sample_weight, rsp_if.avg_weight, rsp_if.is_stable);
               wait_left = burst_mode ? 0 : $urandom_range(0, 4);
            end else if (wait_left != 0) begin
               wait_left--;
            end
            if (hold_request) begin
               hold_request = 1'b0;
               hold_left    = $urandom_range(60, 90);
            end else if (hold_left != 0) begin
               hold_left--;
            end
            rsp_if.ready <= (wait_left == 0) && (hold_left == 0);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: ends the run once the quiet count since reset or the last transfer
   // on either channel reaches HANG_LIMIT.
   // ---------------------------------------------------------------------
   initial begin : hang_watch
      quiet_cycles = 0;
      while (quiet_cycles < HANG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $error("no transfer for %0d cycles, %0d readings still owed",
             HANG_LIMIT, sb.expected_q.size());
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [RAW_W-1:0]   tare;
      logic [SCALE_W-1:0] scale;
      logic [BAND_W-1:0]  band;
      logic [COUNT_W-1:0] count;
      int unsigned        phase;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_TARE_OFFSET;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.raw_sample <= '0;
      burst_mode        = 1'b0;
      hold_request      = 1'b0;
      samples_sent      = 0;
      settings_count    = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults, untouched: zero input, one below / at / above tare,
      // full scale, mid scale, then a held level that fills the cleared window.
      send_sample('0);
      send_sample(TARE_RESET - 1'b1);
      send_sample(TARE_RESET);
      send_sample(TARE_RESET + 1'b1);
      send_sample('1);
      send_sample(24'h800000);
      repeat (8) send_sample(24'h400000);
      wait_drained();

      // No tare, largest coefficient: weight saturates above a 2^20 count;
      // widest band with zero count sets the flag on the first steady mean.
      apply_config('0, '1, '1, '0);
      send_sample('1);
      send_sample(24'h100000);
      send_sample(24'h0FFFFF);
      send_sample(24'h000001);
      send_sample('0);
      send_sample(24'h5A5A5A);
      wait_drained();

      // Largest tare, zero coefficient, zero band: nothing is ever steady.
      apply_config('1, '0, '0, '1);
      send_sample('1);
      send_sample('0);
      send_sample(24'hA5A5A5);
      wait_drained();

      // Random part: a few fixed corner settings, then random ones.
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               tare = TARE_RESET; scale = SCALE_RESET; band = BAND_RESET; count = COUNT_RESET;
            end
            1: begin
               tare = '0; scale = '1; band = '1; count = '0;
            end
            2: begin
               tare = '1; scale = $urandom; band = '0; count = '1;
            end
            3: begin
               // Small weights, widest band: nearly every mean is steady,
               // so the largest count is actually reached.
               tare  = RAW_W'($urandom_range(0, 1000));
               scale = 32'h0000_1000; band = '1; count = '1;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       tare = '0;
                  1:       tare = RAW_W'($urandom_range(0, 65535));
                  default: tare = RAW_W'($urandom);
               endcase
               case ($urandom_range(0, 3))
                  0:       scale = $urandom;
                  1:       scale = $urandom_range(0, 65535);
                  2:       scale = $urandom_range(0, 1 << 24);
                  default: scale = SCALE_RESET ^ SCALE_W'($urandom_range(0, 255));
               endcase
               case ($urandom_range(0, 3))
                  0:       band = '0;
                  1:       band = 16'd1;
                  2:       band = BAND_W'($urandom_range(2, 255));
                  default: band = BAND_W'($urandom);
               endcase
               case ($urandom_range(0, 3))
                  0:       count = '0;
                  1:       count = COUNT_W'($urandom_range(1, 15));
                  2:       count = COUNT_W'($urandom);
                  default: count = '1;
               endcase
            end
         endcase
         burst_mode = ($urandom_range(0, 3) == 0);
         apply_config(tare, scale, band, count);
         run_mixed((phase == 3) ? 300 : 125, (phase == 1) || (phase == 6));
      end

      // Everything owed has arrived; give a stray extra reading time to show.
      burst_mode = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d samples under %0d register settings, %0d readings checked",
               samples_sent, settings_count + 1, sb.checked);
      $display("stable flag expected on %0d readings, %0d saturated sample weights",
               sb.stable_hits, sb.saturated);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
